FILE: src/tanimoto_fingerprint_score_assert.svh
// ---------------------------------------------------------------------------
// Tanimoto fingerprint score: assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef TANIMOTO_FINGERPRINT_SCORE_ASSERT_SVH
`define TANIMOTO_FINGERPRINT_SCORE_ASSERT_SVH

`ifndef SYNTHESIS
`define TFS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tfs assertion failed");
`define TFS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("tfs assertion failed");
`else
`define TFS_ASSERT(lbl, clk, rst_n, prop)
`define TFS_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

FILE: src/tfs_pkg.sv
// ---------------------------------------------------------------------------
// Tanimoto fingerprint score: package
// Widths, bounds, transaction types and helper functions.
// ---------------------------------------------------------------------------
package tfs_pkg;

    localparam int WORD_W    = 64;
    localparam int COUNT_W   = 13;
    localparam int SCORE_W   = 17;
    localparam int POP_W     = $clog2(WORD_W + 1);
    localparam int MAX_WORDS = 64;

    localparam int COUNT_MAX_I = (1 << COUNT_W) - 1;
    localparam int COUNT_CAP_I = (MAX_WORDS * WORD_W > COUNT_MAX_I) ?
                                 COUNT_MAX_I : MAX_WORDS * WORD_W;
    localparam logic [COUNT_W-1:0] COUNT_CAP = COUNT_W'(COUNT_CAP_I);

    localparam int Q_DEPTH  = 4;
    localparam int Q_PTR_W  = $clog2(Q_DEPTH);
    localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

    localparam int DIV_STEPS  = SCORE_W;
    localparam int DIV_STEP_W = $clog2(DIV_STEPS);

    typedef struct packed {
        logic [WORD_W-1:0] query_word;
        logic [WORD_W-1:0] ref_word;
        logic              last_word;
    } t_in;

    typedef struct packed {
        logic [COUNT_W-1:0] and_count;
        logic [COUNT_W-1:0] or_count;
        logic [SCORE_W-1:0] score_q16;
        logic               empty_flag;
    } t_out;

    typedef struct packed {
        logic [COUNT_W-1:0] and_total;
        logic [COUNT_W-1:0] or_total;
    } t_job;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_HOLD
    } t_back_state;

    // lane sums: 2-bit, 4-bit, byte, then folded into the low byte
    function automatic logic [POP_W-1:0] popcount(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] x;
        x = (w & {(WORD_W/2){2'b01}}) + ((w >> 1) & {(WORD_W/2){2'b01}});
        x = (x & {(WORD_W/4){4'h3}}) + ((x >> 2) & {(WORD_W/4){4'h3}});
        x = (x & {(WORD_W/8){8'h0F}}) + ((x >> 4) & {(WORD_W/8){8'h0F}});
        x = x + (x >> 8);
        x = x + (x >> 16);
        x = x + (x >> 32);
        return x[POP_W-1:0];
    endfunction

    function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] acc,
                                                   input logic [POP_W-1:0]   p);
        logic [COUNT_W:0] s;
        s = {1'b0, acc} + (COUNT_W + 1)'(p);
        return (s > {1'b0, COUNT_CAP}) ? COUNT_CAP : s[COUNT_W-1:0];
    endfunction

endpackage

FILE: src/tfs_front.sv
// ---------------------------------------------------------------------------
// Tanimoto fingerprint score: front end
// Takes word pairs, keeps saturating AND/OR popcount totals, and queues a
// job on the last word of each reference.
// ---------------------------------------------------------------------------
`include "tanimoto_fingerprint_score_assert.svh"

module tfs_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  tfs_pkg::t_in  i_item,
    input  logic          i_q_full,
    output logic          o_q_push,
    output tfs_pkg::t_job o_q_data
);
    import tfs_pkg::*;

    logic [COUNT_W-1:0] r_and, n_and;
    logic [COUNT_W-1:0] r_or, n_or;
    logic [COUNT_W-1:0] sum_and, sum_or;
    logic               accept;

    assign full   = i_q_full;
    assign accept = push && !i_q_full;

    assign sum_and = sat_add(r_and, popcount(i_item.query_word & i_item.ref_word));
    assign sum_or  = sat_add(r_or,  popcount(i_item.query_word | i_item.ref_word));

    assign o_q_push           = accept && i_item.last_word;
    assign o_q_data.and_total = sum_and;
    assign o_q_data.or_total  = sum_or;

    always_comb begin
        n_and = r_and;
        n_or  = r_or;
        if (accept) begin
            if (i_item.last_word) begin
                n_and = '0;
                n_or  = '0;
            end else begin
                n_and = sum_and;
                n_or  = sum_or;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_and <= '0;
            r_or  <= '0;
        end else begin
            r_and <= n_and;
            r_or  <= n_or;
        end
    end

    `TFS_ASSERT(a_and_le_or, i_clk, i_rst_n, r_and <= r_or)
    `TFS_ASSERT(a_or_le_cap, i_clk, i_rst_n, r_or <= COUNT_CAP)
    `TFS_ASSERT(a_clear_after_last, i_clk, i_rst_n,
        (accept && i_item.last_word) |=> (r_and == '0 && r_or == '0))

endmodule

FILE: src/tfs_queue.sv
// ---------------------------------------------------------------------------
// Tanimoto fingerprint score: job queue
// Small register queue between the accumulating front end and the divider.
// ---------------------------------------------------------------------------
`include "tanimoto_fingerprint_score_assert.svh"

module tfs_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tfs_pkg::t_job i_data,
    output logic          o_full,
    output logic          o_vld,
    input  logic          i_pop,
    output tfs_pkg::t_job o_data
);
    import tfs_pkg::*;

    t_job               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [Q_CNT_W-1:0] r_count, n_count;
    logic               do_push, do_pop;

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_vld   = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_vld;

    always_comb begin
        n_wr_ptr = do_push ? Q_PTR_W'(r_wr_ptr + 1'b1) : r_wr_ptr;
        n_rd_ptr = do_pop  ? Q_PTR_W'(r_rd_ptr + 1'b1) : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    `TFS_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= Q_CNT_W'(Q_DEPTH))
    `TFS_ASSERT(a_ptr_count, i_clk, i_rst_n,
        (r_count == '0 || r_count == Q_CNT_W'(Q_DEPTH)) |-> (r_wr_ptr == r_rd_ptr))

endmodule

FILE: src/tfs_back.sv
// ---------------------------------------------------------------------------
// Tanimoto fingerprint score: back end
// Restoring divider, one quotient bit per cycle, and the result register.
// ---------------------------------------------------------------------------
`include "tanimoto_fingerprint_score_assert.svh"

module tfs_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_vld,
    output logic          o_q_pop,
    input  tfs_pkg::t_job i_q_data,
    output logic          empty,
    input  logic          pop,
    output tfs_pkg::t_out o_item
);
    import tfs_pkg::*;

    t_back_state           r_state, n_state;
    logic [COUNT_W-1:0]    r_and, n_and;
    logic [COUNT_W-1:0]    r_or, n_or;
    logic [COUNT_W-1:0]    r_rem, n_rem;
    logic [SCORE_W-1:0]    r_bits, n_bits;
    logic [SCORE_W-1:0]    r_quo, n_quo;
    logic [DIV_STEP_W-1:0] r_step, n_step;
    logic                  r_zero, n_zero;
    t_out                  r_out, n_out;
    logic                  r_out_vld, n_out_vld;
    logic [COUNT_W:0]      trial;
    logic                  ge;

    assign empty  = !r_out_vld;
    assign o_item = r_out;

    // Dividend is and_total << 16; and_total <= or_total, so the upper
    // quotient bits are zero and the remainder starts at and_total >> 1.
    assign trial = {r_rem, r_bits[SCORE_W-1]};
    assign ge    = (trial >= {1'b0, r_or});

    always_comb begin
        n_state   = r_state;
        n_and     = r_and;
        n_or      = r_or;
        n_rem     = r_rem;
        n_bits    = r_bits;
        n_quo     = r_quo;
        n_step    = r_step;
        n_zero    = r_zero;
        n_out     = r_out;
        n_out_vld = r_out_vld && !pop;
        o_q_pop   = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (i_q_vld) begin
                    o_q_pop = 1'b1;
                    n_and   = i_q_data.and_total;
                    n_or    = i_q_data.or_total;
                    n_rem   = {1'b0, i_q_data.and_total[COUNT_W-1:1]};
                    n_bits  = {i_q_data.and_total[0], (SCORE_W - 1)'(0)};
                    n_quo   = '0;
                    n_step  = '0;
                    n_zero  = (i_q_data.or_total == '0);
                    n_state = (i_q_data.or_total == '0) ? BK_HOLD : BK_DIV;
                end
            end
            BK_DIV: begin
                n_rem  = ge ? COUNT_W'(trial - {1'b0, r_or}) : trial[COUNT_W-1:0];
                n_quo  = {r_quo[SCORE_W-2:0], ge};
                n_bits = {r_bits[SCORE_W-2:0], 1'b0};
                n_step = r_step + 1'b1;
                if (r_step == DIV_STEP_W'(DIV_STEPS - 1)) begin
                    n_state = BK_HOLD;
                end
            end
            BK_HOLD: begin
                if (!r_out_vld || pop) begin
                    n_out.and_count  = r_and;
                    n_out.or_count   = r_or;
                    n_out.score_q16  = r_zero ? '0 : r_quo;
                    n_out.empty_flag = r_zero;
                    n_out_vld        = 1'b1;
                    n_state          = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BK_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_and  <= n_and;
        r_or   <= n_or;
        r_rem  <= n_rem;
        r_bits <= n_bits;
        r_quo  <= n_quo;
        r_step <= n_step;
        r_zero <= n_zero;
        r_out  <= n_out;
    end

    `TFS_ASSERT(a_rem_lt_div, i_clk, i_rst_n, (r_state == BK_DIV) |-> (r_rem < r_or))
    `TFS_ASSERT(a_score_range, i_clk, i_rst_n,
        r_out_vld |-> (r_out.score_q16 <= SCORE_W'(1 << 16)))
    `TFS_ASSERT(a_empty_flag, i_clk, i_rst_n,
        r_out_vld |-> (r_out.empty_flag == (r_out.or_count == '0)))

endmodule

FILE: src/tanimoto_fingerprint_score.sv
// ---------------------------------------------------------------------------
// Tanimoto fingerprint score: top level
// Tanimoto similarity of bit fingerprints streamed one 64-bit word pair at a
// time.
//
// Input channel: push/full. Each transaction carries a query word, the
// matching reference word and last_word. The front end adds the popcounts
// of AND and OR to saturating totals in the cycle of acceptance, so one
// word is taken every cycle while the job queue has room.
// On last_word the totals go into a four-entry job queue and clear.
// Output channel: empty/pop. The back end runs a restoring divider, one
// quotient bit per cycle, then loads the result register once it is free.
// The divider works on one job at a time and pops the next job from the
// queue only after loading the previous result, so the queue absorbs
// references that end while a division is still running.
// If the receiver stalls, the result register holds, the divider waits,
// and after four more queued references full rises.
// Reset (synchronous, active low) clears the totals, the queue and the
// result valid flag.
// ---------------------------------------------------------------------------
module tanimoto_fingerprint_score (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  tfs_pkg::t_in  i_item,
    output logic          empty,
    input  logic          pop,
    output tfs_pkg::t_out o_item
);
    import tfs_pkg::*;

    logic q_push, q_full, q_vld, q_pop;
    t_job q_wdata, q_rdata;

    tfs_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_data (q_wdata)
    );

    tfs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .o_vld   (q_vld),
        .i_pop   (q_pop),
        .o_data  (q_rdata)
    );

    tfs_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_vld  (q_vld),
        .o_q_pop  (q_pop),
        .i_q_data (q_rdata),
        .empty    (empty),
        .pop      (pop),
        .o_item   (o_item)
    );

endmodule
